// ----- hw/rtl/ftbr_pkg.sv -----
// ----------------------------------------------------------------------------
// ftbr_pkg: shared types and constants of the FAT type classifier
//
// Holds the result codes, the register indexes, the field widths and the
// side-band structs that travel beside the two division chains.
// ----------------------------------------------------------------------------
package ftbr_pkg;

   // Result codes for fs_kind.
   localparam logic [1:0] KIND_FAT12   = 2'd0;
   localparam logic [1:0] KIND_FAT16   = 2'd1;
   localparam logic [1:0] KIND_FAT32   = 2'd2;
   localparam logic [1:0] KIND_INVALID = 2'd3;

   // Configuration register indexes.
   localparam int unsigned CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] REG_FAT16_MIN = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_FAT32_MIN = 1'b1;

   // A root directory entry is 32 bytes, so the byte count is entries << 5.
   localparam int unsigned ROOT_ENTRY_SHIFT = 5;

   // Widths of the arithmetic.
   localparam int unsigned SEC_W      = 32;  // sector counts
   localparam int unsigned ROOT_NUM_W = 22;  // entries * 32 + bps - 1
   localparam int unsigned BPS_W      = 16;
   localparam int unsigned SPC_W      = 8;
   localparam int unsigned TABLE_W    = 40;  // copies * table size
   localparam int unsigned OVH_W      = 41;  // reserved + tables + root

   // Word layouts.
   localparam int unsigned REQ_DATA_W = 160;
   localparam int unsigned RSP_DATA_W = 32;
   localparam int unsigned RSP_USER_W = 2;

   // Fields that ride beside the root directory division.
   typedef struct packed {
      logic               bad;
      logic [SEC_W-1:0]   total;
      logic [15:0]        rsvd;
      logic [TABLE_W-1:0] table_secs;
      logic [SPC_W-1:0]   spc;
   } root_side_type;

   // Fields that ride beside the cluster division.
   typedef struct packed {
      logic bad;
   } clus_side_type;

endpackage

// ----- hw/rtl/ftbr_div_cell.sv -----
// ----------------------------------------------------------------------------
// ftbr_div_cell: one step of a restoring divider
//
// Takes the partial remainder and numerator word from the previous cell,
// retires one quotient bit and registers the result for the next cell.
// The divisor and a side-band payload travel along unchanged.
// ----------------------------------------------------------------------------
module ftbr_div_cell #(
   parameter int unsigned NUM_W = 8,
   parameter int unsigned DEN_W = 8,
   parameter int unsigned PAY_W = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   valid_i,
   input  logic [DEN_W+NUM_W-1:0] acc_i,
   input  logic [DEN_W-1:0]       den_i,
   input  logic [PAY_W-1:0]       pay_i,
   output logic                   valid_o,
   output logic [DEN_W+NUM_W-1:0] acc_o,
   output logic [DEN_W-1:0]       den_o,
   output logic [PAY_W-1:0]       pay_o
);

   localparam int unsigned ACC_W = DEN_W + NUM_W;

   logic [ACC_W:0]   shifted;
   logic [DEN_W:0]   upper;
   logic [DEN_W:0]   diff;
   logic             fits;
   logic [ACC_W-1:0] acc_in;
   logic             valid_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [DEN_W-1:0] den_ff;
   logic [PAY_W-1:0] pay_ff;

   // Shift in the next numerator bit and try to subtract the divisor.
   always_comb begin
      shifted = {acc_i, 1'b0};
      upper   = shifted[ACC_W:NUM_W];
      diff    = upper - {1'b0, den_i};
      fits    = (upper >= {1'b0, den_i});
      if (fits) begin
         acc_in = {diff[DEN_W-1:0], shifted[NUM_W-1:1], 1'b1};
      end else begin
         acc_in = shifted[ACC_W-1:0];
      end
   end

   // Valid flag of this cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   // Working word and side-band.
   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff <= acc_in;
         den_ff <= den_i;
         pay_ff <= pay_i;
      end
   end

   assign valid_o = valid_ff;
   assign acc_o   = acc_ff;
   assign den_o   = den_ff;
   assign pay_o   = pay_ff;

endmodule

// ----- hw/rtl/ftbr_div_chain.sv -----
// ----------------------------------------------------------------------------
// ftbr_div_chain: pipelined unsigned divider built from a row of cells
//
// NUM_W cells each retire one quotient bit, most significant first. A new
// division may enter in every cycle that the pipeline advances.
// ----------------------------------------------------------------------------
module ftbr_div_chain #(
   parameter int unsigned NUM_W = 8,
   parameter int unsigned DEN_W = 8,
   parameter int unsigned PAY_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             valid_i,
   input  logic [NUM_W-1:0] num_i,
   input  logic [DEN_W-1:0] den_i,
   input  logic [PAY_W-1:0] pay_i,
   output logic             valid_o,
   output logic [NUM_W-1:0] quot_o,
   output logic [PAY_W-1:0] pay_o
);

   localparam int unsigned ACC_W = DEN_W + NUM_W;

   logic             valid_w [NUM_W+1];
   logic [ACC_W-1:0] acc_w   [NUM_W+1];
   logic [DEN_W-1:0] den_w   [NUM_W+1];
   logic [PAY_W-1:0] pay_w   [NUM_W+1];

   // The remainder starts at zero with the numerator in the low bits.
   assign valid_w[0] = valid_i;
   assign acc_w[0]   = {{DEN_W{1'b0}}, num_i};
   assign den_w[0]   = den_i;
   assign pay_w[0]   = pay_i;

   // One cell per quotient bit.
   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      ftbr_div_cell #(
         .NUM_W (NUM_W),
         .DEN_W (DEN_W),
         .PAY_W (PAY_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_i (valid_w[i]),
         .acc_i   (acc_w[i]),
         .den_i   (den_w[i]),
         .pay_i   (pay_w[i]),
         .valid_o (valid_w[i+1]),
         .acc_o   (acc_w[i+1]),
         .den_o   (den_w[i+1]),
         .pay_o   (pay_w[i+1])
      );
   end

   assign valid_o = valid_w[NUM_W];
   assign quot_o  = acc_w[NUM_W][NUM_W-1:0];
   assign pay_o   = pay_w[NUM_W];

endmodule

// ----- hw/rtl/fat_type_from_boot_record_core.sv -----
// ----------------------------------------------------------------------------
// fat_type_from_boot_record_core: FAT12/16/32 classifier for boot records
//
// The block takes one word per cycle while results are taken and returns one
// result word per input word, in order. The path runs through one input
// stage, a 22-cell chain that divides the root directory bytes by the
// sector size one quotient bit per cell, two stages that sum the overhead
// sectors and subtract them from the total, a 32-cell chain that divides
// the data sectors by the cluster size, and the output register. When
// rsp_tready is low with a result waiting, the whole pipeline holds and
// req_tready drops in the same cycle. An item with a zero sector size, a
// zero cluster size, or no sectors left for data gives fs_kind invalid (3)
// and a cluster count of zero. The FAT16 threshold is written at csr index
// 0 and the FAT32 threshold at csr index 1; the user must write them only
// while no item is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module fat_type_from_boot_record_core (
   input  logic                                clock,
   input  logic                                reset,
   // Input words.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // total_sectors_short[15:0], total_sectors_long[47:16],
   // reserved_sectors[63:48], fat_copies[71:64], fat_size_short[87:72],
   // fat_size_long[119:88], root_entries[135:120],
   // bytes_per_sector[151:136], sectors_per_cluster[159:152]
   input  logic [ftbr_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Result words.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // cluster_count[31:0]
   output logic [ftbr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // fs_kind[1:0]
   output logic [ftbr_pkg::RSP_USER_W-1:0]     rsp_tuser,
   // Configuration writes.
   input  logic                                csr_we,
   input  logic [ftbr_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [ftbr_pkg::SEC_W-1:0]          csr_wdata
);

   import ftbr_pkg::*;

   // Input fields.
   logic [15:0]       f_tot_s;
   logic [SEC_W-1:0]  f_tot_l;
   logic [15:0]       f_rsvd;
   logic [7:0]        f_copies;
   logic [15:0]       f_fsz_s;
   logic [SEC_W-1:0]  f_fsz_l;
   logic [15:0]       f_roots;
   logic [BPS_W-1:0]  f_bps;
   logic [SPC_W-1:0]  f_spc;

   // Pipeline control.
   logic advance;

   // Threshold registers.
   logic [SEC_W-1:0] fat16_min_ff;
   logic [SEC_W-1:0] fat32_min_ff;

   // Input stage.
   logic              s0_valid_ff;
   logic [ROOT_NUM_W-1:0] s0_num_ff;
   logic [BPS_W-1:0]  s0_den_ff;
   root_side_type     s0_side_ff;
   logic [SEC_W-1:0]  total_sel;
   logic [SEC_W-1:0]  fsz_sel;
   logic [ROOT_NUM_W-1:0] root_num;
   root_side_type     s0_side_in;

   // Root directory division.
   logic              r_valid;
   logic [ROOT_NUM_W-1:0] r_quot;
   logic [$bits(root_side_type)-1:0] r_pay;
   root_side_type     r_side;

   // Overhead stage.
   logic              s1_valid_ff;
   logic [OVH_W-1:0]  s1_ovh_ff;
   logic [SEC_W-1:0]  s1_total_ff;
   logic [SPC_W-1:0]  s1_spc_ff;
   logic              s1_bad_ff;

   // Data sector stage.
   logic              s2_valid_ff;
   logic [SEC_W-1:0]  s2_data_ff;
   logic [SPC_W-1:0]  s2_den_ff;
   clus_side_type     s2_side_ff;
   logic              s2_short;

   // Cluster division.
   logic              c_valid;
   logic [SEC_W-1:0]  c_quot;
   logic [$bits(clus_side_type)-1:0] c_pay;
   clus_side_type     c_side;

   // Output register.
   logic              rsp_valid_ff;
   logic [SEC_W-1:0]  rsp_count_ff;
   logic [1:0]        rsp_kind_ff;
   logic [1:0]        kind_in;
   logic [SEC_W-1:0]  count_in;

   // Unpack the input word.
   assign f_tot_s  = req_tdata[15:0];
   assign f_tot_l  = req_tdata[47:16];
   assign f_rsvd   = req_tdata[63:48];
   assign f_copies = req_tdata[71:64];
   assign f_fsz_s  = req_tdata[87:72];
   assign f_fsz_l  = req_tdata[119:88];
   assign f_roots  = req_tdata[135:120];
   assign f_bps    = req_tdata[151:136];
   assign f_spc    = req_tdata[159:152];

   // The whole pipeline moves unless a finished result is held up.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Threshold registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fat16_min_ff <= SEC_W'(4085);
         fat32_min_ff <= SEC_W'(65525);
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_FAT16_MIN: fat16_min_ff <= csr_wdata;
            REG_FAT32_MIN: fat32_min_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pick the short or long counts and form the root directory byte count.
   always_comb begin
      total_sel = (f_tot_s != 16'd0) ? {16'd0, f_tot_s} : f_tot_l;
      fsz_sel   = (f_fsz_s != 16'd0) ? {16'd0, f_fsz_s} : f_fsz_l;
      root_num  = ({6'd0, f_roots} << ROOT_ENTRY_SHIFT)
                  + {6'd0, f_bps} - ROOT_NUM_W'(1);
      s0_side_in.bad        = (f_bps == '0) || (f_spc == '0);
      s0_side_in.total      = total_sel;
      s0_side_in.rsvd       = f_rsvd;
      s0_side_in.table_secs = TABLE_W'(f_copies) * TABLE_W'(fsz_sel);
      s0_side_in.spc        = f_spc;
   end

   // Input stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_num_ff  <= root_num;
         s0_den_ff  <= (f_bps == '0) ? BPS_W'(1) : f_bps;
         s0_side_ff <= s0_side_in;
      end
   end

   // Root directory sectors, rounded up.
   ftbr_div_chain #(
      .NUM_W (ROOT_NUM_W),
      .DEN_W (BPS_W),
      .PAY_W ($bits(root_side_type))
   ) u_root_div (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .valid_i (s0_valid_ff),
      .num_i   (s0_num_ff),
      .den_i   (s0_den_ff),
      .pay_i   (s0_side_ff),
      .valid_o (r_valid),
      .quot_o  (r_quot),
      .pay_o   (r_pay)
   );

   assign r_side = root_side_type'(r_pay);

   // Sum reserved, table and root directory sectors without wrap.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= r_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ovh_ff   <= OVH_W'(r_side.rsvd) + OVH_W'(r_side.table_secs)
                        + OVH_W'(r_quot);
         s1_total_ff <= r_side.total;
         s1_spc_ff   <= r_side.spc;
         s1_bad_ff   <= r_side.bad;
      end
   end

   // Data sectors; nothing left for data marks the geometry invalid.
   assign s2_short = (s1_ovh_ff >= OVH_W'(s1_total_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_data_ff     <= s1_total_ff - s1_ovh_ff[SEC_W-1:0];
         s2_den_ff      <= (s1_spc_ff == '0) ? SPC_W'(1) : s1_spc_ff;
         s2_side_ff.bad <= s1_bad_ff || s2_short;
      end
   end

   // Cluster count.
   ftbr_div_chain #(
      .NUM_W (SEC_W),
      .DEN_W (SPC_W),
      .PAY_W ($bits(clus_side_type))
   ) u_clus_div (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .valid_i (s2_valid_ff),
      .num_i   (s2_data_ff),
      .den_i   (s2_den_ff),
      .pay_i   (s2_side_ff),
      .valid_o (c_valid),
      .quot_o  (c_quot),
      .pay_o   (c_pay)
   );

   assign c_side = clus_side_type'(c_pay);

   // Classify against the thresholds; the FAT32 test takes priority.
   always_comb begin
      count_in = c_quot;
      priority if (c_side.bad) begin
         kind_in  = KIND_INVALID;
         count_in = '0;
      end else if (c_quot >= fat32_min_ff) begin
         kind_in = KIND_FAT32;
      end else if (c_quot >= fat16_min_ff) begin
         kind_in = KIND_FAT16;
      end else begin
         kind_in = KIND_FAT12;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= c_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_count_ff <= count_in;
         rsp_kind_ff  <= kind_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_count_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

// ----- dv/fat_type_from_boot_record_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fat_type_from_boot_record_core_test: self-checking bench for the classifier
//
// Drives boot record geometry words into the block: a short directed set of
// corner cases, then random records under several threshold settings. Most
// of the random records are well formed, half of those aimed at the thresholds, and the
// rest are raw noise or broken geometry. A scoreboard classifies every
// accepted word on its own and compares each result word, in order, against
// that expectation. Both sides of the stream idle at random, and once the
// result side holds off long enough for the input side to stall.
// ----------------------------------------------------------------------------
module fat_type_from_boot_record_core_test;
   import ftbr_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned HOLD_LEN      = 400;
   localparam int unsigned DRAIN_CYCLES  = 70;

   // One boot record; the last field listed sits in the lowest bits of the word.
   typedef struct packed {
      logic [7:0]  sectors_per_cluster;
      logic [15:0] bytes_per_sector;
      logic [15:0] root_entries;
      logic [31:0] fat_size_long;
      logic [15:0] fat_size_short;
      logic [7:0]  fat_copies;
      logic [15:0] reserved_sectors;
      logic [31:0] total_sectors_long;
      logic [15:0] total_sectors_short;
   } boot_geometry_type;

   // Classification of one volume.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] clusters;
   } volume_class_type;

   // Keeps the thresholds and the classifications still awaited from the block.
   class fat_kind_board_type;
      logic [31:0]      fat16_min;
      logic [31:0]      fat32_min;
      volume_class_type awaited_kinds[$];
      int               errors;

      function new();
         fat16_min = 32'd4085;
         fat32_min = 32'd65525;
         errors    = 0;
      endfunction

      function void set_thresholds(logic [31:0] f16, logic [31:0] f32);
         fat16_min = f16;
         fat32_min = f32;
      endfunction

      // Work out the volume type of one record from its geometry.
      function volume_class_type classify_volume(boot_geometry_type g);
         logic [63:0]      total, fat_size, table_secs, root_secs, overhead, data_secs;
         volume_class_type r;
         total    = (g.total_sectors_short != 0) ? 64'(g.total_sectors_short)
                                                 : 64'(g.total_sectors_long);
         fat_size = (g.fat_size_short != 0) ? 64'(g.fat_size_short)
                                            : 64'(g.fat_size_long);
         r.kind     = KIND_INVALID;
         r.clusters = '0;
         if (g.bytes_per_sector != 0 && g.sectors_per_cluster != 0) begin
            table_secs = 64'(g.fat_copies) * fat_size;
            root_secs  = ((64'(g.root_entries) << ROOT_ENTRY_SHIFT)
                          + 64'(g.bytes_per_sector) - 64'd1) / 64'(g.bytes_per_sector);
            overhead   = 64'(g.reserved_sectors) + table_secs + root_secs;
            if (overhead < total) begin
               data_secs  = total - overhead;
               r.clusters = 32'(data_secs / 64'(g.sectors_per_cluster));
               r.kind     = KIND_FAT12;
               if (r.clusters >= fat16_min) r.kind = KIND_FAT16;
               if (r.clusters >= fat32_min) r.kind = KIND_FAT32;
            end
         end
         return r;
      endfunction

      function void note_record(boot_geometry_type g);
         awaited_kinds.push_back(classify_volume(g));
      endfunction

      // Compare one result word with the oldest expectation.
      function void check_result(logic [1:0] kind, logic [31:0] clusters);
         volume_class_type want;
         if (awaited_kinds.size() == 0) begin
            $display("%0t: unexpected result word, kind %0d clusters %0d",
                     $time, kind, clusters);
            errors++;
            return;
         end
         want = awaited_kinds.pop_front();
         if (kind !== want.kind) begin
            $display("%0t: fs_kind mismatch, expected %0d actual %0d",
                     $time, want.kind, kind);
            errors++;
         end
         if (clusters !== want.clusters) begin
            $display("%0t: cluster_count mismatch, expected %0d actual %0d",
                     $time, want.clusters, clusters);
            errors++;
         end
      endfunction

      function int pending_count();
         return awaited_kinds.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [SEC_W-1:0]      csr_wdata = '0;

   fat_kind_board_type board = new();
   int unsigned        send_idle_pct = 21;
   int unsigned        recv_idle_pct = 48;
   logic               hold_armed = 1'b0;
   int unsigned        hold_cycles = 0;
   int unsigned        cycle_count = 0;

   fat_type_from_boot_record_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side: check each accepted word, then decide on the next ready.
   // The long hold-off is counted here once the main sequence arms it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tuser, rsp_tdata);
      if (hold_armed && hold_cycles < HOLD_LEN) begin
         hold_cycles <= hold_cycles + 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Build a well-formed record whose data area holds the given cluster count
   // plus a slack of sectors that does not make up a whole cluster.
   function automatic boot_geometry_type target_geometry(
         longint unsigned clusters, int unsigned spc, int unsigned bps,
         int unsigned rsvd, int unsigned copies, int unsigned fat_size,
         int unsigned roots, int unsigned slack);
      boot_geometry_type g;
      longint unsigned   overhead, total;
      overhead = longint'(rsvd) + longint'(copies) * longint'(fat_size)
                 + ((longint'(roots) << ROOT_ENTRY_SHIFT) + bps - 1) / bps;
      total    = overhead + clusters * spc + slack;
      if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
      g                     = '0;
      g.sectors_per_cluster = spc[7:0];
      g.bytes_per_sector    = bps[15:0];
      g.root_entries        = roots[15:0];
      g.fat_size_long       = fat_size;
      g.fat_copies          = copies[7:0];
      g.reserved_sectors    = rsvd[15:0];
      g.total_sectors_long  = total[31:0];
      return g;
   endfunction

   // Random record: mostly realistic geometry, half of it aimed near the thresholds,
   // some broken geometry and some raw noise.
   function automatic boot_geometry_type random_geometry();
      boot_geometry_type g;
      int unsigned       roll, spc, bps, rsvd, copies, fat_size, roots, sel;
      longint unsigned   anchor, clusters;
      roll = $urandom_range(99);
      if (roll < 10) begin
         g = {$urandom, $urandom, $urandom, $urandom, $urandom};
         if ($urandom_range(1) == 0) g.total_sectors_short = '0;
         if ($urandom_range(1) == 0) g.fat_size_short = '0;
         return g;
      end
      spc      = ($urandom_range(3) == 0) ? $urandom_range(1, 255) : 1 << $urandom_range(0, 7);
      bps      = ($urandom_range(3) == 0) ? $urandom_range(1, 65535)
                                          : 1 << $urandom_range(9, 12);
      rsvd     = $urandom_range(0, 63);
      copies   = ($urandom_range(9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 4);
      fat_size = $urandom_range(1, 70000);
      roots    = $urandom_range(0, 2047);
      sel      = $urandom_range(3);
      case (sel)
         0: anchor = board.fat16_min;
         1: anchor = board.fat32_min;
         2: anchor = $urandom_range(0, 1 << 20);
         default: anchor = $urandom >> $urandom_range(0, 31);
      endcase
      clusters = anchor + $urandom_range(0, 4);
      clusters = (clusters < 2) ? 0 : clusters - 2;
      if (roll < 20) begin
         // Broken geometry: a zero divisor or no room left for data.
         sel = $urandom_range(2);
         g   = target_geometry(clusters, spc, bps, rsvd, copies, fat_size, roots,
                               $urandom_range(0, spc - 1));
         case (sel)
            0: g.bytes_per_sector = '0;
            1: g.sectors_per_cluster = '0;
            default: begin
               g = target_geometry(0, spc, bps, rsvd, copies, fat_size, roots, 0);
               g.total_sectors_long = g.total_sectors_long - $urandom_range(0, 3);
            end
         endcase
      end else begin
         g = target_geometry(clusters, spc, bps, rsvd, copies, fat_size, roots,
                             $urandom_range(0, spc - 1));
      end
      // Move counts that fit into the 16-bit fields, leaving junk in the long ones.
      if (g.total_sectors_long != 0 && g.total_sectors_long <= 65535
          && $urandom_range(1) == 1) begin
         g.total_sectors_short = g.total_sectors_long[15:0];
         g.total_sectors_long  = $urandom;
      end
      if (g.fat_size_long != 0 && g.fat_size_long <= 65535 && $urandom_range(1) == 1) begin
         g.fat_size_short = g.fat_size_long[15:0];
         g.fat_size_long  = $urandom;
      end
      return g;
   endfunction

   // Offer one record after a random gap and wait until it is taken.
   task automatic send_record(boot_geometry_type g);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= g;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_record(g);
   endtask

   // Stop offering and wait for every result still in flight.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.pending_count() != 0) @(posedge clock);
   endtask

   // Write both thresholds on back-to-back cycles; the block is idle here.
   task automatic set_thresholds(logic [31:0] f16, logic [31:0] f32);
      csr_we    <= 1'b1;
      csr_addr  <= REG_FAT16_MIN;
      csr_wdata <= f16;
      @(posedge clock);
      csr_addr  <= REG_FAT32_MIN;
      csr_wdata <= f32;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_thresholds(f16, f32);
   endtask

   task automatic run_random(int unsigned count, int unsigned s_idle, int unsigned r_idle);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      repeat (count) send_record(random_geometry());
      drain_results();
   endtask

   initial begin
      boot_geometry_type directed_q[$];
      boot_geometry_type g;
      logic [31:0]       f16;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners under the reset thresholds.
      g = '0;
      directed_q.push_back(g);                                  // all zero
      g = '1;
      directed_q.push_back(g);                                  // all ones
      g = target_geometry(5000, 4, 512, 32, 2, 100, 512, 0);
      g.bytes_per_sector = '0;
      directed_q.push_back(g);                                  // zero sector size
      g = target_geometry(5000, 4, 512, 32, 2, 100, 512, 0);
      g.sectors_per_cluster = '0;
      directed_q.push_back(g);                                  // zero cluster size
      directed_q.push_back(target_geometry(0, 1, 512, 32, 2, 100, 512, 0)); // no data
      g = target_geometry(0, 1, 512, 32, 2, 100, 512, 0);
      g.total_sectors_long = g.total_sectors_long - 1;
      directed_q.push_back(g);                                  // overhead past total
      directed_q.push_back(target_geometry(1, 1, 512, 32, 2, 100, 512, 0));
      directed_q.push_back(target_geometry(0, 8, 512, 32, 2, 100, 512, 5)); // under one cluster
      directed_q.push_back(target_geometry(4084, 4, 512, 32, 2, 100, 512, 3));
      directed_q.push_back(target_geometry(4085, 4, 512, 32, 2, 100, 512, 0));
      directed_q.push_back(target_geometry(65524, 2, 512, 32, 2, 300, 512, 1));
      directed_q.push_back(target_geometry(65525, 2, 512, 32, 2, 300, 512, 0));
      directed_q.push_back(target_geometry(64'hFFFF_FFFF, 1, 1, 0, 0, 0, 0, 0)); // max clusters
      g = target_geometry(100, 1, 512, 0, 255, 0, 0, 0);
      g.fat_size_long = '1;
      directed_q.push_back(g);                                  // huge tables
      g = target_geometry(3000, 1, 512, 32, 2, 9, 16, 0);
      g.total_sectors_short = g.total_sectors_long[15:0];
      g.total_sectors_long  = 32'h0000_0123;
      g.fat_size_short      = 16'd9;
      g.fat_size_long       = '1;
      directed_q.push_back(g);                                  // short fields win
      directed_q.push_back(target_geometry(70000, 1, 1, 1, 1, 1, 65535, 0));
      directed_q.push_back(target_geometry(70000, 1, 65535, 1, 1, 1, 65535, 0));
      directed_q.push_back(target_geometry(20, 1, 65535, 0, 0, 0, 1, 0)); // root rounds up
      directed_q.push_back(target_geometry(9000, 255, 4096, 32, 2, 1000, 512, 254));
      send_idle_pct = 21;
      recv_idle_pct = 48;
      foreach (directed_q[i]) send_record(directed_q[i]);
      drain_results();

      // Everything below the top threshold classifies as FAT16.
      set_thresholds(32'd0, 32'hFFFF_FFFF);
      run_random(200, 21, 48);

      // FAT32 threshold below the FAT16 one.
      set_thresholds(32'd100000, 32'd5000);
      run_random(250, 21, 48);

      // Standard thresholds, with a long hold-off on the result side.
      set_thresholds(32'd4085, 32'd65525);
      hold_armed <= 1'b1;
      run_random(300, 48, 21);

      // Every valid count reaches FAT32.
      set_thresholds(32'hFFFF_FFFF, 32'd0);
      run_random(150, 48, 21);

      // Random thresholds, no idling on either side.
      f16 = $urandom_range(1, 1 << 16);
      set_thresholds(f16, f16 + $urandom_range(0, 1 << 20));
      run_random(500, 0, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
